FILE: sv/ssq_pkg.sv
package ssq_pkg;

  // register map
  localparam logic REG_BREATH_RATE  = 1'b0;
  localparam logic REG_STROKE_STEPS = 1'b1;

  localparam int unsigned RATE_W    = 5;
  localparam int unsigned STEPS_W   = 4;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned TICK_CNT_W = 13;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 5'd5;
  localparam logic [RATE_W-1:0]  RATE_MIN    = 5'd5;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 5'd30;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 4'd0;

  localparam logic [STEPS_W-1:0]    MAX_STEPS       = 4'd8;
  localparam logic [TICK_CNT_W-1:0] INDICATOR_TICKS = 13'd500;

  // servo positions
  localparam logic [POS_W-1:0] REST_POS = 12'd2000;
  localparam logic [POS_W-1:0] FULL_POS = 12'd4000;
  localparam int unsigned      STEP_POS = 250;

  // dwell = half a minute in ms over rate * steps
  localparam int unsigned DWELL_NUM  = 60000 / 2;
  localparam int unsigned NUM_W      = $clog2(DWELL_NUM + 1);
  localparam int unsigned DEN_W      = RATE_W + STEPS_W;
  localparam int unsigned ITER_CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    PH_RISE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_FALL  = 2'd2
  } phase_e;

endpackage

FILE: sv/ssq_in_if.sv
interface ssq_in_if;
  logic valid;
  logic ready;
  logic ms_tick;

  modport source (output valid, output ms_tick, input ready);
  modport sink (input valid, input ms_tick, output ready);
endinterface

FILE: sv/ssq_out_if.sv
interface ssq_out_if;
  logic                      valid;
  logic                      ready;
  logic [ssq_pkg::POS_W-1:0] servo_compare;
  logic                      indicator_on;

  modport source (output valid, output servo_compare, output indicator_on, input ready);
  modport sink (input valid, input servo_compare, input indicator_on, output ready);
endinterface

FILE: sv/servo_stroke_sweep_sequencer.sv
// channel  | dir | payload                          | handshake
// in_i     | in  | ms_tick                          | valid / ready
// out_o    | out | servo_compare, indicator_on      | valid / ready
// cfg      | in  | cfg_idx_i, cfg_data_i            | cfg_we_i, always taken
//
// A request without a tick, or one inside a position, is handled in ST_IDLE.
// A tick that starts a rise or fall position runs the bit-serial divider for the
// dwell, with in_i.ready low until it is done, so no new request is taken meanwhile.
// The result is built from the state held before the tick and is registered
// the cycle after acceptance; a two-slot output buffer takes one more request
// while a result is stalled. Reset leaves the servo at rest, rising, index 0.
module servo_stroke_sweep_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssq_in_if.sink                        in_i,
  ssq_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ssq_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [ssq_pkg::POS_W-1:0] pos;
    logic                      ind;
  } result_t;

  state_e                            state_q;
  logic [ssq_pkg::RATE_W-1:0]        rate_q;
  logic [ssq_pkg::STEPS_W-1:0]       steps_q;
  ssq_pkg::phase_e                   phase_q;
  logic [ssq_pkg::STEPS_W-1:0]       idx_q;
  logic [ssq_pkg::TICK_CNT_W-1:0]    elapsed_q;
  logic [ssq_pkg::TICK_CNT_W-1:0]    dwell_q;
  result_t                           main_q, spare_q;
  logic                              main_vld_q, spare_vld_q;

  logic [ssq_pkg::STEPS_W-1:0]       steps_eff;
  logic [ssq_pkg::RATE_W-1:0]        rate_eff;
  logic [ssq_pkg::DEN_W-1:0]         den;
  logic [ssq_pkg::TICK_CNT_W:0]      pos_raw;
  result_t                           res;
  logic                              accept, pop, need_div;
  logic                              div_done;
  logic [ssq_pkg::TICK_CNT_W-1:0]    div_quo;
  logic [ssq_pkg::TICK_CNT_W-1:0]    len, elapsed_inc;
  ssq_pkg::phase_e                   phase_n;
  logic [ssq_pkg::STEPS_W-1:0]       idx_n;
  logic [ssq_pkg::TICK_CNT_W-1:0]    elapsed_n;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= ssq_pkg::RATE_RESET;
      steps_q <= ssq_pkg::STEPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssq_pkg::REG_BREATH_RATE:  rate_q  <= cfg_data_i[ssq_pkg::RATE_W-1:0];
        ssq_pkg::REG_STROKE_STEPS: steps_q <= cfg_data_i[ssq_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings and dwell divisor
  always_comb begin
    steps_eff = (steps_q > ssq_pkg::MAX_STEPS) ? ssq_pkg::MAX_STEPS : steps_q;
    if (rate_q < ssq_pkg::RATE_MIN) begin
      rate_eff = ssq_pkg::RATE_MIN;
    end else if (rate_q > ssq_pkg::RATE_MAX) begin
      rate_eff = ssq_pkg::RATE_MAX;
    end else begin
      rate_eff = rate_q;
    end
    den = ssq_pkg::DEN_W'(rate_eff) * ssq_pkg::DEN_W'(steps_eff);
  end

  // result from the state held before the tick
  always_comb begin
    pos_raw = (ssq_pkg::TICK_CNT_W + 1)'(ssq_pkg::REST_POS)
            + (ssq_pkg::TICK_CNT_W + 1)'(ssq_pkg::STEP_POS) * (ssq_pkg::TICK_CNT_W + 1)'(idx_q);
    if (steps_eff == '0) begin
      res.pos = ssq_pkg::REST_POS;
      res.ind = 1'b0;
    end else if (phase_q == ssq_pkg::PH_PULSE) begin
      res.pos = ssq_pkg::REST_POS;
      res.ind = 1'b1;
    end else begin
      res.pos = (pos_raw > (ssq_pkg::TICK_CNT_W + 1)'(ssq_pkg::FULL_POS))
              ? ssq_pkg::FULL_POS : pos_raw[ssq_pkg::POS_W-1:0];
      res.ind = 1'b0;
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE) && !spare_vld_q;
  assign accept              = in_i.valid && in_i.ready;
  assign pop                 = main_vld_q && out_o.ready;
  assign out_o.valid         = main_vld_q;
  assign out_o.servo_compare = main_q.pos;
  assign out_o.indicator_on  = main_q.ind;

  // a position other than the pulse needs a fresh dwell on its first tick
  assign need_div = accept && in_i.ms_tick && (steps_eff != '0)
                 && (elapsed_q == '0) && (phase_q != ssq_pkg::PH_PULSE);

  ssq_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (need_div),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // dwell length in force for this tick and the sequence step after it
  always_comb begin
    if (state_q == ST_DIV) begin
      len = div_quo;
    end else if (elapsed_q == '0) begin
      len = ssq_pkg::INDICATOR_TICKS;
    end else begin
      len = dwell_q;
    end
    elapsed_inc = elapsed_q + 1'b1;
    phase_n     = phase_q;
    idx_n       = idx_q;
    elapsed_n   = elapsed_inc;
    if (elapsed_inc >= len) begin
      elapsed_n = '0;
      unique case (phase_q)
        ssq_pkg::PH_PULSE: begin
          if (steps_eff > ssq_pkg::STEPS_W'(1)) begin
            phase_n = ssq_pkg::PH_RISE;
            idx_n   = ssq_pkg::STEPS_W'(1);
          end else begin
            phase_n = ssq_pkg::PH_FALL;
            idx_n   = steps_eff;
          end
        end
        ssq_pkg::PH_FALL: begin
          if (idx_q > ssq_pkg::STEPS_W'(1)) begin
            idx_n = idx_q - 1'b1;
          end else begin
            phase_n = ssq_pkg::PH_RISE;
            idx_n   = '0;
          end
        end
        default: begin
          if (idx_q == '0) begin
            phase_n = ssq_pkg::PH_PULSE;
          end else if (({1'b0, idx_q} + 1'b1) < {1'b0, steps_eff}) begin
            idx_n = idx_q + 1'b1;
          end else begin
            phase_n = ssq_pkg::PH_FALL;
            idx_n   = steps_eff;
          end
        end
      endcase
    end
  end

  // sequencer, sweep state and output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= ssq_pkg::PH_RISE;
      idx_q       <= '0;
      elapsed_q   <= '0;
      dwell_q     <= '0;
      main_q      <= '0;
      spare_q     <= '0;
      main_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (steps_eff == '0) begin
              phase_q   <= ssq_pkg::PH_RISE;
              idx_q     <= '0;
              elapsed_q <= '0;
            end else if (need_div) begin
              state_q <= ST_DIV;
            end else if (in_i.ms_tick) begin
              if (elapsed_q == '0) begin
                dwell_q <= ssq_pkg::INDICATOR_TICKS;
              end
              phase_q   <= phase_n;
              idx_q     <= idx_n;
              elapsed_q <= elapsed_n;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q   <= ST_IDLE;
            dwell_q   <= div_quo;
            phase_q   <= phase_n;
            idx_q     <= idx_n;
            elapsed_q <= elapsed_n;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // two-slot result buffer
      if (pop) begin
        if (spare_vld_q) begin
          main_q      <= spare_q;
          spare_vld_q <= 1'b0;
        end else if (accept) begin
          main_q <= res;
        end else begin
          main_vld_q <= 1'b0;
        end
      end else if (accept) begin
        if (main_vld_q) begin
          spare_q     <= res;
          spare_vld_q <= 1'b1;
        end else begin
          main_q     <= res;
          main_vld_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/ssq_divider.sv
module ssq_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ssq_pkg::DEN_W-1:0]      den_i,
  output logic                           done_o,
  output logic [ssq_pkg::TICK_CNT_W-1:0] quo_o
);

  localparam logic [ssq_pkg::ITER_CNT_W-1:0] LastIter =
    ssq_pkg::ITER_CNT_W'(ssq_pkg::NUM_W - 1);

  logic                            busy_q;
  logic [ssq_pkg::ITER_CNT_W-1:0]  cnt_q;
  logic [ssq_pkg::DEN_W-1:0]       den_q;
  logic [ssq_pkg::DEN_W-1:0]       rem_q, rem_d;
  logic [ssq_pkg::NUM_W-1:0]       shr_q, shr_d;
  logic [ssq_pkg::DEN_W:0]         trial;
  logic                            fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, shr_q[ssq_pkg::NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? ssq_pkg::DEN_W'(trial - {1'b0, den_q}) : ssq_pkg::DEN_W'(trial);
    shr_d = {shr_q[ssq_pkg::NUM_W-2:0], fits};
  end

  assign done_o = busy_q && (cnt_q == LastIter);
  assign quo_o  = shr_d[ssq_pkg::TICK_CNT_W-1:0];

  // iteration control, dividend bits leave as quotient bits enter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastIter) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      shr_q <= ssq_pkg::NUM_W'(ssq_pkg::DWELL_NUM);
    end else if (busy_q) begin
      rem_q <= rem_d;
      shr_q <= shr_d;
    end
  end

endmodule

FILE: sv/ssq_checker.sv
module ssq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [ssq_pkg::POS_W-1:0] servo_compare_i,
  input logic                      indicator_on_i
);

  // every accepted request shows a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("no result after accepted request");

  // compare value stays within the servo travel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (servo_compare_i >= ssq_pkg::REST_POS)
                 && (servo_compare_i <= ssq_pkg::FULL_POS))
    else $error("servo compare out of travel");

  // the indicator pulse only runs with the servo at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && indicator_on_i) |-> (servo_compare_i == ssq_pkg::REST_POS))
    else $error("indicator on away from rest");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(servo_compare_i)
                                   && $stable(indicator_on_i))
    else $error("stalled result changed");

endmodule

bind servo_stroke_sweep_sequencer ssq_checker u_ssq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .servo_compare_i (out_o.servo_compare),
  .indicator_on_i  (out_o.indicator_on)
);

FILE: sim/servo_stroke_sweep_sequencer_checker.sv
module servo_stroke_sweep_sequencer_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ssq_in_if                     in_mon_i,
  ssq_out_if                    out_mon_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [ssq_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned           err_cnt_o,
  output int unsigned           pending_o
);
  import ssq_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] servo_compare;
    logic             indicator_on;
  } servo_out_t;

  // shadow of the sweep state and the registers
  logic [RATE_W-1:0]     rate_cfg;
  logic [STEPS_W-1:0]    steps_cfg;
  phase_e                phase;
  logic [STEPS_W-1:0]    pos_idx;
  logic [TICK_CNT_W-1:0] elapsed;
  logic [TICK_CNT_W-1:0] dwell_len;

  servo_out_t servo_due_q[$];
  servo_out_t got_due;

  // output for one request, then the tick applied to the sweep state
  task automatic predict_servo(input logic tick);
    logic [STEPS_W-1:0] n_steps;
    logic [RATE_W-1:0]  rate_eff;
    int unsigned        pos;
    int unsigned        quot;
    servo_out_t         res;
    n_steps  = (steps_cfg > MAX_STEPS) ? MAX_STEPS : steps_cfg;
    rate_eff = (rate_cfg < RATE_MIN) ? RATE_MIN : (rate_cfg > RATE_MAX) ? RATE_MAX : rate_cfg;
    if (n_steps == 0) begin
      // rest hold resets the sequence
      phase   = PH_RISE;
      pos_idx = '0;
      elapsed = '0;
      res.servo_compare = REST_POS;
      res.indicator_on  = 1'b0;
    end else begin
      if (phase == PH_PULSE) begin
        res.servo_compare = REST_POS;
        res.indicator_on  = 1'b1;
      end else begin
        pos = REST_POS + STEP_POS * pos_idx;
        if (pos > FULL_POS) pos = FULL_POS;
        res.servo_compare = pos[POS_W-1:0];
        res.indicator_on  = 1'b0;
      end
      if (tick) begin
        // dwell is latched on the first tick of each position
        if (elapsed == 0) begin
          if (phase == PH_PULSE) begin
            dwell_len = INDICATOR_TICKS;
          end else begin
            quot      = DWELL_NUM / (rate_eff * n_steps);
            dwell_len = quot[TICK_CNT_W-1:0];
          end
        end
        elapsed = elapsed + 1'b1;
        if (elapsed >= dwell_len) begin
          elapsed = '0;
          case (phase)
            PH_PULSE: begin
              if (n_steps > 1) begin
                phase   = PH_RISE;
                pos_idx = STEPS_W'(1);
              end else begin
                phase   = PH_FALL;
                pos_idx = n_steps;
              end
            end
            PH_FALL: begin
              if (pos_idx > 1) begin
                pos_idx = pos_idx - 1'b1;
              end else begin
                phase   = PH_RISE;
                pos_idx = '0;
              end
            end
            default: begin
              // rise ends early if the step count shrank
              if (pos_idx == 0) begin
                phase = PH_PULSE;
              end else if (pos_idx + 1 < n_steps) begin
                pos_idx = pos_idx + 1'b1;
              end else begin
                phase   = PH_FALL;
                pos_idx = n_steps;
              end
            end
          endcase
        end
      end
    end
    servo_due_q.push_back(res);
  endtask

  // compare results, predict accepted requests, track register writes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    if (!rst_ni) begin
      rate_cfg  = RATE_RESET;
      steps_cfg = STEPS_RESET;
      phase     = PH_RISE;
      pos_idx   = '0;
      elapsed   = '0;
      dwell_len = '0;
      servo_due_q.delete();
      err_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (servo_due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual servo_compare %0d indicator_on %0b",
                   $time, out_mon_i.servo_compare, out_mon_i.indicator_on);
          err_cnt_o++;
        end else begin
          got_due = servo_due_q.pop_front();
          if (out_mon_i.servo_compare !== got_due.servo_compare) begin
            $display("%0t: servo_compare mismatch, expected %0d actual %0d",
                     $time, got_due.servo_compare, out_mon_i.servo_compare);
            err_cnt_o++;
          end
          if (out_mon_i.indicator_on !== got_due.indicator_on) begin
            $display("%0t: indicator_on mismatch, expected %0b actual %0b",
                     $time, got_due.indicator_on, out_mon_i.indicator_on);
            err_cnt_o++;
          end
        end
      end
      // a request and a write on the same edge see the old settings
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_servo(in_mon_i.ms_tick);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BREATH_RATE) begin
          rate_cfg = cfg_data_i[RATE_W-1:0];
        end else begin
          steps_cfg = cfg_data_i[STEPS_W-1:0];
        end
      end
      pending_o <= servo_due_q.size();
    end
  end

endmodule

FILE: sim/servo_stroke_sweep_sequencer_test.sv
module servo_stroke_sweep_sequencer_test;
  import ssq_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  int unsigned      fail_cnt;
  int unsigned      pending_cnt;
  int unsigned      burst_left;

  ssq_in_if  in_ch ();
  ssq_out_if out_ch ();

  always #6 clk_i = ~clk_i;

  servo_stroke_sweep_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  servo_stroke_sweep_sequencer_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon_i   (in_ch),
    .out_mon_i  (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .err_cnt_o  (fail_cnt),
    .pending_o  (pending_cnt)
  );

  // one request, sent in bursts with random gaps between them
  task automatic send_item(input logic tick);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.ms_tick <= tick;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stop sending until every result is back and the divider is idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_cnt != 0 || !in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: stall patterns plus a long hold-off now and then
  initial begin : result_sink
    int unsigned blk;
    int unsigned k;
    int unsigned mode;
    logic [31:0] pat;
    out_ch.ready <= 1'b0;
    blk = 0;
    wait (rst_ni == 1'b1);
    forever begin
      blk++;
      if (blk % 40 == 3) begin
        // output buffer fills up and the input has to stall
        for (k = 0; k < 400; k++) begin
          @(posedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      pat  = $urandom;
      for (k = 0; k < 32; k++) begin
        @(posedge clk_i);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= pat[k];
          2: out_ch.ready <= pat[k] | pat[(k + 5) % 32];
          default: out_ch.ready <= (k % 4) != 0;
        endcase
      end
    end
  end

  // request side
  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    int unsigned n;
    logic [CFG_W-1:0] val;
    in_ch.valid   <= 1'b0;
    in_ch.ms_tick <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_BREATH_RATE;
    cfg_data_i    <= '0;
    burst_left = 0;
    wait (rst_ni == 1'b1);
    @(posedge clk_i);

    // rest hold out of reset, idle slot and tick
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    drain();

    // fast sweep: shortest dwell, the first position runs into the pulse
    write_reg(REG_BREATH_RATE, 5'd30);
    write_reg(REG_STROKE_STEPS, 5'd8);
    repeat (140) send_item(1'b1);
    drain();

    // rate below range, steps above the maximum
    write_reg(REG_BREATH_RATE, 5'd0);
    write_reg(REG_STROKE_STEPS, 5'd15);
    send_item(1'b0);
    repeat (4) send_item(1'b1);
    send_item(1'b0);
    drain();

    // rate above range, one step, upper data bit ignored, change inside a position
    write_reg(REG_BREATH_RATE, 5'd31);
    write_reg(REG_STROKE_STEPS, 5'b10001);
    repeat (4) send_item(1'b1);
    drain();

    // back to rest in the middle of a stroke
    write_reg(REG_STROKE_STEPS, 5'd0);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // random phases: short runs under changing settings
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: val = CFG_W'($urandom_range(0, 4));
          1: val = 5'd31;
          2: val = 5'd30;
          3: val = 5'd5;
          default: val = CFG_W'($urandom_range(20, 30));
        endcase
        write_reg(REG_BREATH_RATE, val);
      end
      if (ph == 0 || $urandom_range(0, 2) != 0) begin
        val = ($urandom_range(0, 6) == 0) ? CFG_W'($urandom_range(0, 1) << 4)
                                          : CFG_W'($urandom_range(0, 31));
        write_reg(REG_STROKE_STEPS, val);
      end
      n = $urandom_range(20, 60);
      for (k = 0; k < n; k++) begin
        send_item($urandom_range(0, 9) != 0);
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
